// ----- rtl/uns_pkg.sv -----
// ----------------------------------------------------------------------------
// uns_pkg
// Shared types and constants for the UTF-8 name sanitiser.
// ----------------------------------------------------------------------------
package uns_pkg;

   // Byte values with a special meaning in the input stream.
   localparam logic [7:0] BYTE_NUL   = 8'h00;
   localparam logic [7:0] BYTE_TAB   = 8'h09;
   localparam logic [7:0] BYTE_SPACE = 8'h20;
   localparam logic [7:0] BYTE_DEL   = 8'h7F;
   localparam logic [7:0] LEAD_TWO   = 8'h80;
   localparam logic [7:0] LEAD_THREE = 8'hE0;
   localparam logic [7:0] LEAD_FOUR  = 8'hF0;

   // Width of the capacity register.
   localparam int unsigned CAP_WIDTH = 9;
   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 9'd256;

   // One result item as held in the output queue.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_last;
      logic [7:0] length;
   } result_type;

endpackage

// ----- rtl/utf8_name_sanitizer.sv -----
// ----------------------------------------------------------------------------
// utf8_name_sanitizer
// Streaming name cleaner: collapses blanks, drops control bytes, copies UTF-8
// sequences whole and truncates at a configurable length.
// ----------------------------------------------------------------------------
// Usage.
// The request channel (req_valid/req_ready/req_in_byte) takes one byte of a
// name per request; a zero byte ends the name. The response channel
// (rsp_valid/rsp_ready) returns the sanitised bytes, each with the running
// length, and one terminator response (rsp_is_last high, byte zero) carrying
// the final length. csr_wr_en/csr_wr_data set the output capacity, which
// should be written while no name is in progress.
// The first response to an accepted request is registered and appears
// in the cycle after acceptance. A request is accepted every cycle while
// responses are taken, except that a request producing a pending space
// plus a character yields two responses; the next request waits until the
// first of them is taken. The rate is set by the two-entry response queue.
// The per-byte decode and the length check sit between the request edge and
// the queue registers. Reset empties the queue, clears the name state and
// sets the capacity to 256. When the receiver stalls, the queue holds its
// responses and req_ready falls once it cannot take a further two responses.
// ----------------------------------------------------------------------------
module utf8_name_sanitizer
   import uns_pkg::*;
#(
   parameter int unsigned NAME_MAX_BYTES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   // Configuration
   input  logic                 csr_wr_en,
   input  logic [CAP_WIDTH-1:0] csr_wr_data,
   // Requests
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_in_byte,
   // Responses
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_is_last,
   output logic [7:0]           rsp_length
);

   localparam logic [CAP_WIDTH-1:0] MaxBytes = CAP_WIDTH'(NAME_MAX_BYTES);

   // Configuration and name state.
   logic [CAP_WIDTH-1:0] capacity_ff;
   logic [7:0]           emitted_ff, emitted_in;
   logic                 space_ff, space_in;
   logic [1:0]           cont_ff, cont_in;
   logic                 trunc_ff, trunc_in;

   // Two-entry response queue.
   result_type           head_ff, head_in;
   result_type           tail_ff, tail_in;
   logic [1:0]           count_ff, count_in;

   // Decode signals.
   result_type           res0, res1;
   logic [1:0]           n_res;
   logic [2:0]           seq_len;
   logic [7:0]           limit;
   logic [CAP_WIDTH-1:0] cap_minus_one;
   logic [9:0]           needed;
   logic                 accept;
   logic                 pop;
   logic                 is_blank;
   logic                 is_ctrl;

   assign accept = req_valid & req_ready;
   assign pop    = rsp_valid & rsp_ready;

   // Room for two responses once this cycle's pop has happened.
   assign req_ready = (count_ff == 2'd0) || ((count_ff == 2'd1) && rsp_ready);

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_out_byte = head_ff.out_byte;
   assign rsp_is_last  = head_ff.is_last;
   assign rsp_length   = head_ff.length;

   // Length limit: capacity less the terminator, capped at the maximum.
   assign cap_minus_one = capacity_ff - CAP_WIDTH'(1);
   always_comb begin
      if (capacity_ff == '0) begin
         limit = 8'd0;
      end else if (cap_minus_one > MaxBytes) begin
         limit = MaxBytes[7:0];
      end else begin
         limit = cap_minus_one[7:0];
      end
   end

   // Sequence length from the lead byte.
   always_comb begin
      if (req_in_byte < LEAD_TWO) begin
         seq_len = 3'd1;
      end else if (req_in_byte < LEAD_THREE) begin
         seq_len = 3'd2;
      end else if (req_in_byte < LEAD_FOUR) begin
         seq_len = 3'd3;
      end else begin
         seq_len = 3'd4;
      end
   end

   assign is_blank = (req_in_byte == BYTE_SPACE) || (req_in_byte == BYTE_TAB);
   assign is_ctrl  = (req_in_byte < BYTE_SPACE) || (req_in_byte == BYTE_DEL);
   assign needed   = {2'b00, emitted_ff} + {9'd0, space_ff} + {7'd0, seq_len};

   // Per-byte decode: next name state and the responses this request makes.
   always_comb begin
      emitted_in = emitted_ff;
      space_in   = space_ff;
      cont_in    = cont_ff;
      trunc_in   = trunc_ff;
      n_res      = 2'd0;
      res0       = '{out_byte: req_in_byte, is_last: 1'b0, length: emitted_ff + 8'd1};
      res1       = '{out_byte: req_in_byte, is_last: 1'b0, length: emitted_ff + 8'd2};
      if (req_in_byte == BYTE_NUL) begin
         res0       = '{out_byte: BYTE_NUL, is_last: 1'b1, length: emitted_ff};
         n_res      = 2'd1;
         emitted_in = 8'd0;
         space_in   = 1'b0;
         cont_in    = 2'd0;
         trunc_in   = 1'b0;
      end else if (!trunc_ff) begin
         if (cont_ff != 2'd0) begin
            // Continuation bytes are copied raw.
            n_res      = 2'd1;
            emitted_in = emitted_ff + 8'd1;
            cont_in    = cont_ff - 2'd1;
         end else if (is_blank) begin
            space_in = (emitted_ff != 8'd0);
         end else if (!is_ctrl) begin
            if (needed > {2'b00, limit}) begin
               trunc_in = 1'b1;
            end else begin
               cont_in  = seq_len[1:0] - 2'd1;
               space_in = 1'b0;
               if (space_ff) begin
                  res0.out_byte = BYTE_SPACE;
                  n_res         = 2'd2;
                  emitted_in    = emitted_ff + 8'd2;
               end else begin
                  n_res      = 2'd1;
                  emitted_in = emitted_ff + 8'd1;
               end
            end
         end
      end
   end

   // Response queue next state. Requests enter only an empty or emptying queue.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (accept) begin
         head_in  = res0;
         tail_in  = res1;
         count_in = n_res;
      end else if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 2'd1;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         emitted_ff  <= 8'd0;
         space_ff    <= 1'b0;
         cont_ff     <= 2'd0;
         trunc_ff    <= 1'b0;
         count_ff    <= 2'd0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (accept) begin
            emitted_ff <= emitted_in;
            space_ff   <= space_in;
            cont_ff    <= cont_in;
            trunc_ff   <= trunc_in;
         end
         count_ff <= count_in;
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   // The queue never holds more than two responses.
   assert property (@(posedge clock) disable iff (reset) count_ff != 2'd3)
      else $error("response queue overflow");

   // A full queue never takes a request.
   assert property (@(posedge clock) disable iff (reset) (count_ff == 2'd2) |-> !req_ready)
      else $error("request taken with full response queue");

   // A terminating byte gives a terminator response and clears the count.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_byte == BYTE_NUL) |=>
         (rsp_valid && rsp_is_last && count_ff == 2'd1 && emitted_ff == 8'd0))
      else $error("terminator not produced");

   // A sequence is never left open once copying has stopped.
   assert property (@(posedge clock) disable iff (reset) (cont_ff != 2'd0) |-> !trunc_ff)
      else $error("continuation pending while truncated");

   // A response held back by the receiver keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(head_ff)))
      else $error("stalled response changed");

endmodule

// ----- bench/name_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_check_pkg
// Expected-response store for the UTF-8 name sanitiser bench. It keeps its
// own copy of the name state, works out the responses due for each accepted
// request and compares the responses that arrive against them, in order.
// ----------------------------------------------------------------------------
package name_check_pkg;
   import uns_pkg::*;

   // Upper bound on the name length, also passed to the block.
   localparam int unsigned NAME_LIMIT = 64;

   class name_scoreboard;
      logic [CAP_WIDTH-1:0] capacity;
      logic [7:0]           emitted;
      logic                 space_pending;
      logic [1:0]           cont_left;
      logic                 truncated;
      int                   mismatches;
      result_type           expected_bytes[$];

      function new();
         capacity      = CAP_RESET;
         emitted       = '0;
         space_pending = 1'b0;
         cont_left     = '0;
         truncated     = 1'b0;
         mismatches    = 0;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void push_byte(logic [7:0] value, logic last, logic [7:0] len);
         result_type r;
         r.out_byte = value;
         r.is_last  = last;
         r.length   = len;
         expected_bytes.push_back(r);
      endfunction

      // Works out the responses that one accepted request byte causes.
      function void note_request(logic [7:0] in_byte);
         int unsigned seq_len;
         int unsigned limit;
         // A zero byte closes the name with its final length.
         if (in_byte == BYTE_NUL) begin
            push_byte(BYTE_NUL, 1'b1, emitted);
            emitted       = '0;
            space_pending = 1'b0;
            cont_left     = '0;
            truncated     = 1'b0;
            return;
         end
         if (truncated) return;
         // Continuation bytes are copied as they are, whatever their value.
         if (cont_left != 0) begin
            emitted   = emitted + 8'd1;
            cont_left = cont_left - 2'd1;
            push_byte(in_byte, 1'b0, emitted);
            return;
         end
         // Blanks only arm a space, and only once something has been emitted.
         if (in_byte == BYTE_SPACE || in_byte == BYTE_TAB) begin
            space_pending = (emitted != 0);
            return;
         end
         if (in_byte < BYTE_SPACE || in_byte == BYTE_DEL) return;
         if (in_byte < LEAD_TWO)        seq_len = 1;
         else if (in_byte < LEAD_THREE) seq_len = 2;
         else if (in_byte < LEAD_FOUR)  seq_len = 3;
         else                           seq_len = 4;
         // The limit is the capacity less the terminator, capped at the maximum.
         limit = (capacity == 0) ? 0 : int'(capacity) - 1;
         if (limit > NAME_LIMIT) limit = NAME_LIMIT;
         if (int'(emitted) + int'(space_pending) + seq_len > limit) begin
            truncated = 1'b1;
            return;
         end
         if (space_pending) begin
            emitted       = emitted + 8'd1;
            push_byte(BYTE_SPACE, 1'b0, emitted);
            space_pending = 1'b0;
         end
         emitted   = emitted + 8'd1;
         push_byte(in_byte, 1'b0, emitted);
         cont_left = 2'(seq_len - 1);
      endfunction

      // Compares one accepted response with the oldest one expected.
      function void check_response(logic [7:0] out_byte, logic is_last, logic [7:0] len);
         result_type want;
         if (expected_bytes.size() == 0) begin
            $error("response 0x%02h last=%0b length=%0d arrived with none expected",
                   out_byte, is_last, len);
            mismatches++;
            return;
         end
         want = expected_bytes.pop_front();
         if (out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_byte);
            mismatches++;
         end
         if (is_last !== want.is_last) begin
            $error("is_last: expected %0b, got %0b", want.is_last, is_last);
            mismatches++;
         end
         if (len !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, len);
            mismatches++;
         end
      endfunction
   endclass

endpackage

// ----- bench/utf8_name_sanitizer_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_name_sanitizer_tb
// Self-checking bench for the UTF-8 name sanitiser. A short directed run
// covers blank collapsing, dropped control bytes, every sequence length,
// stray and cut-off sequences, truncation and zero capacity; random names
// then follow over a range of capacities, with bursty requests, receiver
// stalls, one long receiver hold-off and pauses until the block drains.
// ----------------------------------------------------------------------------
module utf8_name_sanitizer_tb;
   import uns_pkg::*;
   import name_check_pkg::*;

   localparam int SETTLE_CYCLES = 4;
   localparam int LONG_HOLD     = 80;
   localparam int PHASE_COUNT   = 10;
   localparam int PHASE_ITEMS   = 26;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_mode_type;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_wr_en;
   logic [CAP_WIDTH-1:0] csr_wr_data;
   logic                 req_valid;
   logic                 req_ready;
   logic [7:0]           req_in_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [7:0]           rsp_out_byte;
   logic                 rsp_is_last;
   logic [7:0]           rsp_length;

   name_scoreboard sb;
   rx_mode_type    stall_mode    = RX_ALWAYS;
   bit             hold_request  = 1'b0;
   int             burst_left    = 0;
   int             burst_max     = 1000;
   int             gap_max       = 1;
   int             requests_sent = 0;

   utf8_name_sanitizer #(.NAME_MAX_BYTES(NAME_LIMIT)) dut (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last),
      .rsp_length   (rsp_length)
   );

   always #10 clock = ~clock;

   // Safety net against a hung handshake.
   initial begin
      #4_000_000;
      $display("** utf8_name_sanitizer: FAILED **");
      $finish;
   end

   // Every accepted response is checked at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response(rsp_out_byte, rsp_is_last, rsp_length);
   end

   // Receiver: its own stall pattern, plus a long hold-off on request.
   initial begin : receiver
      int cycle_count;
      int hold_left;
      cycle_count = 0;
      hold_left   = 0;
      rsp_ready   = 1'b0;
      forever begin
         @(negedge clock);
         cycle_count++;
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               RX_ALWAYS:   rsp_ready <= 1'b1;
               RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
               RX_PERIODIC: rsp_ready <= (cycle_count % 5) >= 2;
               default:     rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // All driving tasks start and end on a falling edge.
   task automatic send_request(input logic [7:0] value);
      int gap;
      // Close the burst with a random gap before the next one starts.
      if (burst_left == 0) begin
         gap = $urandom_range(1, gap_max);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, burst_max);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_in_byte <= value;
      do @(posedge clock); while (!req_ready);
      sb.note_request(value);
      requests_sent++;
      @(negedge clock);
   endtask

   // Stop offering and wait until every expected response has arrived.
   task automatic wait_all_responses();
      req_valid <= 1'b0;
      burst_left = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Capacity writes happen only while the block is idle.
   task automatic set_capacity(input logic [CAP_WIDTH-1:0] cap);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      sb.capacity = cap;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_list(input logic [7:0] bytes[$]);
      foreach (bytes[i]) send_request(bytes[i]);
   endtask

   // A random name built from tokens: plain characters, blank runs, UTF-8
   // sequences (now and then cut short or carrying odd continuations),
   // control bytes and raw noise, always closed by a zero byte.
   task automatic send_random_name(input int max_tokens, input bit pause_inside);
      int          tokens;
      int          kind;
      int          seq_len;
      int          cont;
      logic [7:0]  lead;
      tokens = $urandom_range(1, max_tokens);
      for (int t = 0; t < tokens; t++) begin
         if (pause_inside && t == tokens / 2) wait_all_responses();
         kind = $urandom_range(0, 99);
         if (kind < 45) begin
            send_request(8'($urandom_range(8'h21, 8'h7E)));
         end else if (kind < 60) begin
            repeat ($urandom_range(1, 3))
               send_request($urandom_range(0, 1) ? BYTE_SPACE : BYTE_TAB);
         end else if (kind < 80) begin
            seq_len = $urandom_range(2, 4);
            case (seq_len)
               2:       lead = 8'($urandom_range(8'hC2, 8'hDF));
               3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
               default: lead = 8'($urandom_range(8'hF0, 8'hF7));
            endcase
            send_request(lead);
            cont = ($urandom_range(0, 9) == 0) ? $urandom_range(0, seq_len - 1)
                                               : seq_len - 1;
            repeat (cont) begin
               if ($urandom_range(0, 7) == 0) send_request(8'($urandom_range(1, 255)));
               else send_request(8'($urandom_range(8'h80, 8'hBF)));
            end
         end else if (kind < 88) begin
            if ($urandom_range(0, 3) == 0) send_request(BYTE_DEL);
            else send_request(8'($urandom_range(1, 8'h1F)));
         end else begin
            send_request(8'($urandom_range(1, 255)));
         end
      end
      send_request(BYTE_NUL);
   endtask

   initial begin : main
      logic [CAP_WIDTH-1:0] cap;
      logic [CAP_WIDTH-1:0] cap_table[PHASE_COUNT];
      int                   phase_target;
      bit                   paused_once;
      sb          = new();
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      req_valid   = 1'b0;
      req_in_byte = '0;
      cap_table   = '{9'd256, 9'd1, 9'd2, 9'd5, 9'd65, 9'd66, 9'd511, 9'd0, 9'd64, 9'd3};
      paused_once = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: leading, inner and trailing blanks, control bytes, every
      // sequence length, a continuation that looks like a tab, and a stray
      // continuation byte taken as a two-byte lead.
      send_list('{BYTE_SPACE, 8'h41, BYTE_TAB, BYTE_SPACE, 8'h42, 8'h01, BYTE_DEL,
                  8'hC3, BYTE_TAB, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80,
                  8'h80, 8'h41, BYTE_SPACE, BYTE_NUL});
      // A name that ends in the middle of a four-byte sequence.
      send_list('{8'hFF, BYTE_NUL});
      wait_all_responses();
      // Truncation: the pending space and a two-byte sequence do not fit.
      set_capacity(9'd3);
      send_list('{8'h41, BYTE_SPACE, 8'hC3, 8'h42, BYTE_NUL});
      wait_all_responses();
      // Zero capacity: only the terminator, with length zero.
      set_capacity(9'd0);
      send_list('{8'h41, BYTE_NUL});
      wait_all_responses();

      // Random names over a range of capacities and traffic patterns.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         cap = (phase == PHASE_COUNT - 1) ? CAP_WIDTH'($urandom_range(0, 511))
                                          : cap_table[phase];
         if (phase == PHASE_COUNT - 1 && $urandom_range(0, 1)) cap = cap_table[phase];
         set_capacity(cap);
         stall_mode = rx_mode_type'(phase % 4);
         burst_max  = (phase % 3 == 0) ? 1000 : $urandom_range(2, 8);
         gap_max    = (phase % 3 == 1) ? 2 : 8;
         // Hold the receiver off while requests keep coming, to fill the block.
         if (phase == 3) hold_request = 1'b1;
         phase_target = requests_sent + PHASE_ITEMS;
         while (requests_sent < phase_target) begin
            send_random_name(($urandom_range(0, 5) == 0) ? 50 : 12,
                             phase == 5 && !paused_once);
            if (phase == 5) paused_once = 1'b1;
         end
         wait_all_responses();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("** utf8_name_sanitizer: PASSED **");
      else
         $display("** utf8_name_sanitizer: FAILED **");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/uns_pkg.sv
rtl/utf8_name_sanitizer.sv
bench/name_check_pkg.sv
bench/utf8_name_sanitizer_tb.sv
